/* hdl/r2ifft_pkg.sv */
// ----------------------------------------------------------------------------
// r2ifft_pkg: shared types and constants for the radix-2 inverse FFT core
// Payload structs, data widths and the quarter-wave cosine table.
// ----------------------------------------------------------------------------
package r2ifft_pkg;

	localparam int SampleW = 16;
	localparam int DataW   = 24;
	localparam int TwW     = 18;

	typedef struct packed {
		logic signed [SampleW-1:0] sample_re;
		logic signed [SampleW-1:0] sample_im;
	} sample_t;

	typedef struct packed {
		logic signed [DataW-1:0] result_re;
		logic signed [DataW-1:0] result_im;
		logic                    result_last;
	} result_t;

	// round(65536 * cos(m * pi / 32)), m = 0..16
	function automatic logic [16:0] quarter_cos(input logic [4:0] m);
		logic [16:0] v;
		unique case (m)
			5'd0:  v = 17'd65536;
			5'd1:  v = 17'd65220;
			5'd2:  v = 17'd64277;
			5'd3:  v = 17'd62714;
			5'd4:  v = 17'd60547;
			5'd5:  v = 17'd57798;
			5'd6:  v = 17'd54491;
			5'd7:  v = 17'd50660;
			5'd8:  v = 17'd46341;
			5'd9:  v = 17'd41576;
			5'd10: v = 17'd36410;
			5'd11: v = 17'd30893;
			5'd12: v = 17'd25080;
			5'd13: v = 17'd19024;
			5'd14: v = 17'd12785;
			5'd15: v = 17'd6424;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

	// cos(m * 2pi / 64) in Q2.16
	function automatic logic signed [TwW-1:0] cos64(input logic [5:0] m);
		logic [3:0]  r;
		logic [16:0] a;
		logic [16:0] b;
		logic signed [TwW-1:0] v;
		r = m[3:0];
		a = quarter_cos({1'b0, r});
		b = quarter_cos(5'd16 - {1'b0, r});
		unique case (m[5:4])
			2'd0: v = $signed({1'b0, a});
			2'd1: v = -$signed({1'b0, b});
			2'd2: v = -$signed({1'b0, a});
			default: v = $signed({1'b0, b});
		endcase
		return v;
	endfunction

endpackage

/* hdl/radix2_inverse_fft_core.sv */
// ----------------------------------------------------------------------------
// radix2_inverse_fft_core: unnormalized radix-2 inverse FFT
// Loads a frame, runs passes through one butterfly between two RAMs, unloads results.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one complex Q1.15
//   sample per transaction, in natural order. POINTS samples make a frame.
//   Loading runs at one transaction per cycle.
//   After the last sample of a frame, in_stall rises and the core runs
//   LOG2_POINTS passes. Each butterfly output takes two RAM reads, four
//   real products in the shared multiplier, rounding, add and write; the
//   passes ping-pong between two RAMs. Then it emits POINTS result
//   transactions in natural order on out_valid / out_stall / out_data,
//   result_last set on the final one; in_stall stays high until the unload
//   ends. The unload runs one point per cycle while the receiver takes
//   them; when out_stall is high with out_valid set, the output register
//   holds and the RAM read address does not advance. The cost per loaded
//   sample is set by the single multiplier.
//   Reset clears the sequencer and the load counter; the RAMs are not
//   cleared, since every read follows a write of the same frame.
// ----------------------------------------------------------------------------
module radix2_inverse_fft_core #(
	parameter int LOG2_POINTS = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  r2ifft_pkg::sample_t  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output r2ifft_pkg::result_t  out_data
);

	localparam int Points = 1 << LOG2_POINTS;
	localparam int AW     = LOG2_POINTS;
	localparam int PW     = $clog2(LOG2_POINTS + 1);
	localparam int DW     = r2ifft_pkg::DataW;

	localparam logic [1:0] StLoad   = 2'd0;
	localparam logic [1:0] StPass   = 2'd1;
	localparam logic [1:0] StUnload = 2'd2;

	logic [1:0]    state_q;
	logic [AW-1:0] cnt_q;      // load index, butterfly index
	logic [PW-1:0] pass_q;     // 1..LOG2_POINTS
	logic [2:0]    phase_q;
	logic          bank_q;     // RAM that holds current data
	logic [AW:0]   ucnt_q;     // unload reads issued
	logic          rd_v_q;     // read data valid in unload pipe

	// RAMs
	logic          we0, we1;
	logic [AW-1:0] wa0, wa1, ra0, ra1;
	logic [2*DW-1:0] wd0, wd1, rd0, rd1;

	r2ifft_ram #(.Width(2*DW), .Depth(Points)) u_ram0 (
		.clk(clk), .we(we0), .waddr(wa0), .wdata(wd0), .raddr(ra0), .rdata(rd0));
	r2ifft_ram #(.Width(2*DW), .Depth(Points)) u_ram1 (
		.clk(clk), .we(we1), .waddr(wa1), .wdata(wd1), .raddr(ra1), .rdata(rd1));

	function automatic logic [AW-1:0] bitrev(input logic [AW-1:0] v);
		logic [AW-1:0] r;
		for (int k = 0; k < AW; k++) r[k] = v[AW-1-k];
		return r;
	endfunction

	// butterfly addresses
	logic [AW-1:0] bsel, i0, i1, tw_t;
	logic [AW-1:0] shifted;
	logic [5:0]    tw_m;
	logic [PW-1:0] bitpos;

	assign bitpos  = PW'(LOG2_POINTS) - pass_q;
	assign bsel    = AW'(1) << bitpos;
	assign i0      = cnt_q & ~bsel;
	assign i1      = cnt_q | bsel;
	assign shifted = cnt_q >> bitpos;
	assign tw_t    = bitrev(shifted);
	assign tw_m    = 6'(tw_t) << (6 - LOG2_POINTS);

	// read source bank data, held in registers for the butterfly
	logic [2*DW-1:0] src_rd;
	logic signed [DW-1:0] a_re_q, a_im_q, b_re_q, b_im_q;
	logic signed [DW-1:0] y_re, y_im;
	logic signed [r2ifft_pkg::TwW-1:0] w_re_q, w_im_q;

	assign src_rd = bank_q ? rd1 : rd0;

	r2ifft_bfly u_bfly (
		.clk(clk), .phase(phase_q - 3'd2),
		.b_re(b_re_q), .b_im(b_im_q), .w_re(w_re_q), .w_im(w_im_q),
		.a_re(a_re_q), .a_im(a_im_q), .y_re(y_re), .y_im(y_im));

	// Pass phases: 0 read i1, 1 read i0 / latch b, 2 latch a, 2..7 bfly,
	// write at phase 8 (bfly phase 5 results visible next cycle).
	logic [3:0] ph_q;
	logic       wr_pass;
	logic [AW-1:0] ra_pass;
	assign wr_pass = (state_q == StPass) && (ph_q == 4'd8);
	assign ra_pass = (ph_q == 4'd0) ? i1 : i0;

	assign in_stall = (state_q != StLoad);
	logic load_fire;
	assign load_fire = in_valid && !in_stall;

	// unload: read bitrev(k) from data bank
	logic out_adv;
	assign out_adv = !out_valid || !out_stall;

	// while stalled, re-read the last issued point so the read data holds
	logic [AW-1:0] ucnt_rd;
	assign ucnt_rd = out_adv ? ucnt_q[AW-1:0] : ucnt_q[AW-1:0] - AW'(1);

	always_comb begin
		we0 = 1'b0; we1 = 1'b0;
		wa0 = cnt_q; wa1 = cnt_q;
		wd0 = {DW'(in_data.sample_re), DW'(in_data.sample_im)};
		wd1 = {y_re, y_im};
		ra0 = ra_pass; ra1 = ra_pass;
		priority if (state_q == StLoad) begin
			we0 = load_fire;
		end else if (state_q == StPass) begin
			we0 = wr_pass && bank_q;
			we1 = wr_pass && !bank_q;
			wd0 = {y_re, y_im};
		end else begin
			ra0 = bitrev(ucnt_rd);
			ra1 = bitrev(ucnt_rd);
		end
	end

	logic issue;
	assign issue = (state_q == StUnload) && !ucnt_q[AW] && out_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= StLoad;
			cnt_q     <= '0;
			pass_q    <= PW'(1);
			ph_q      <= '0;
			bank_q    <= 1'b0;
			ucnt_q    <= '0;
			rd_v_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				StLoad: begin
					if (load_fire) begin
						cnt_q <= cnt_q + AW'(1);
						if (cnt_q == AW'(Points - 1)) begin
							state_q <= StPass;
							pass_q  <= PW'(1);
							ph_q    <= '0;
							bank_q  <= 1'b0;
						end
					end
				end
				StPass: begin
					if (ph_q == 4'd8) begin
						ph_q  <= '0;
						cnt_q <= cnt_q + AW'(1);
						if (cnt_q == AW'(Points - 1)) begin
							bank_q <= !bank_q;
							if (pass_q == PW'(LOG2_POINTS)) begin
								state_q <= StUnload;
								ucnt_q  <= '0;
								rd_v_q  <= 1'b0;
							end else begin
								pass_q <= pass_q + PW'(1);
							end
						end
					end else begin
						ph_q <= ph_q + 4'd1;
					end
				end
				default: begin
					if (out_adv) begin
						rd_v_q    <= issue;
						out_valid <= rd_v_q;
						if (issue) ucnt_q <= ucnt_q + (AW+1)'(1);
						if (ucnt_q[AW] && !rd_v_q && (!out_valid || !out_stall)) begin
							state_q   <= StLoad;
							out_valid <= 1'b0;
						end
					end
				end
			endcase
		end
	end

	assign phase_q = ph_q[2:0];

	always_ff @(posedge clk) begin
		if (state_q == StPass) begin
			if (ph_q == 4'd1) begin
				b_re_q <= src_rd[2*DW-1:DW];
				b_im_q <= src_rd[DW-1:0];
				w_re_q <= r2ifft_pkg::cos64(tw_m);
				w_im_q <= r2ifft_pkg::cos64(tw_m + 6'd48);
			end
			if (ph_q == 4'd2) begin
				a_re_q <= src_rd[2*DW-1:DW];
				a_im_q <= src_rd[DW-1:0];
			end
		end
		if (state_q == StUnload && out_adv && rd_v_q) begin
			out_data.result_re   <= src_rd[2*DW-1:DW];
			out_data.result_im   <= src_rd[DW-1:0];
			out_data.result_last <= ucnt_q[AW];
		end
	end

endmodule

/* hdl/r2ifft_ram.sv */
// ----------------------------------------------------------------------------
// r2ifft_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module r2ifft_ram #(
	parameter int Width = 48,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hdl/r2ifft_bfly.sv */
// ----------------------------------------------------------------------------
// r2ifft_bfly: shared butterfly datapath
// Complex product with one real multiplier reused four times, then add.
// ----------------------------------------------------------------------------
module r2ifft_bfly (
	input  logic                                 clk,
	input  logic [2:0]                           phase,
	input  logic signed [r2ifft_pkg::DataW-1:0]  b_re,
	input  logic signed [r2ifft_pkg::DataW-1:0]  b_im,
	input  logic signed [r2ifft_pkg::TwW-1:0]    w_re,
	input  logic signed [r2ifft_pkg::TwW-1:0]    w_im,
	input  logic signed [r2ifft_pkg::DataW-1:0]  a_re,
	input  logic signed [r2ifft_pkg::DataW-1:0]  a_im,
	output logic signed [r2ifft_pkg::DataW-1:0]  y_re,
	output logic signed [r2ifft_pkg::DataW-1:0]  y_im
);

	localparam int ProdW = r2ifft_pkg::DataW + r2ifft_pkg::TwW;
	localparam int AccW  = ProdW + 1;

	logic signed [r2ifft_pkg::DataW-1:0] mx;
	logic signed [r2ifft_pkg::TwW-1:0]   my;
	logic signed [ProdW-1:0]             prod_q;
	logic signed [AccW-1:0]              acc_q;
	logic signed [AccW-1:0]              rnd;

	// phase 0: br*wr  1: bi*wi  2: br*wi  3: bi*wr (each product is registered and lands in the next cycle)
	always_comb begin
		unique case (phase[1:0])
			2'd0: begin mx = b_re; my = w_re; end
			2'd1: begin mx = b_im; my = w_im; end
			2'd2: begin mx = b_re; my = w_im; end
			default: begin mx = b_im; my = w_re; end
		endcase
	end

	assign rnd = acc_q + AccW'(32768);

	always_ff @(posedge clk) begin
		prod_q <= mx * my;
		unique case (phase)
			3'd1: acc_q <= AccW'(prod_q);
			3'd2: acc_q <= acc_q - AccW'(prod_q);
			3'd3: begin
				y_re  <= a_re + rnd[16 +: r2ifft_pkg::DataW];
				acc_q <= AccW'(prod_q);
			end
			3'd4: acc_q <= acc_q + AccW'(prod_q);
			3'd5: y_im <= a_im + rnd[16 +: r2ifft_pkg::DataW];
			default: ;
		endcase
	end

endmodule

/* hdl/r2ifft_checker.sv */
// ----------------------------------------------------------------------------
// r2ifft_checker: port-level assertions for the inverse FFT core
// Checks the handshake and the frame framing seen at the ports.
// ----------------------------------------------------------------------------
module r2ifft_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input r2ifft_pkg::sample_t in_data,
	input logic                out_valid,
	input logic                out_stall,
	input r2ifft_pkg::result_t out_data
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_data))
		else $error("sample dropped or changed while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result dropped or changed while stalled");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input accepted during unload");

	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_data.result_last |=> !out_valid)
		else $error("result after final point");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result during reset");

endmodule

bind radix2_inverse_fft_core r2ifft_checker u_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
	.out_data(out_data));

/* test/tb_radix2_inverse_fft_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radix2_inverse_fft_checker: output predictor and scoreboard
// Mirrors each accepted sample into a frame buffer, computes the inverse
// transform of a finished frame in fixed point and compares every output point.
// ----------------------------------------------------------------------------
module tb_radix2_inverse_fft_checker #(
	parameter int LOG2_POINTS = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  r2ifft_pkg::sample_t  in_data,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  r2ifft_pkg::result_t  out_data,
	output int                   fail_count,
	output int                   pending_points
);

	localparam int Points = 1 << LOG2_POINTS;

	logic signed [r2ifft_pkg::DataW-1:0] frame_re [Points];
	logic signed [r2ifft_pkg::DataW-1:0] frame_im [Points];
	int                                  samples_loaded;
	r2ifft_pkg::result_t                 expected_points [$];

	function automatic int bit_reverse(input int v);
		int r;
		r = 0;
		for (int k = 0; k < LOG2_POINTS; k++) begin
			r = (r << 1) | ((v >> k) & 1);
		end
		return r;
	endfunction

	// floor((p + 2^15) / 2^16); arithmetic shift floors
	function automatic longint round_q16(input longint p);
		return (p + 64'sd32768) >>> 16;
	endfunction

	task automatic predict_frame();
		logic signed [r2ifft_pkg::DataW-1:0] prev_re [Points];
		logic signed [r2ifft_pkg::DataW-1:0] prev_im [Points];
		r2ifft_pkg::result_t r;
		int      b, lo, hi, m;
		longint  wr, wi, br, bi;
		for (int pass = 1; pass <= LOG2_POINTS; pass++) begin
			b = LOG2_POINTS - pass;
			prev_re = frame_re;
			prev_im = frame_im;
			for (int i = 0; i < Points; i++) begin
				lo = i & ~(1 << b);
				hi = i | (1 << b);
				m  = (bit_reverse(i >> b) << (6 - LOG2_POINTS)) & 63;
				wr = r2ifft_pkg::cos64(6'(m));
				wi = r2ifft_pkg::cos64(6'((m + 48) & 63));
				br = prev_re[hi];
				bi = prev_im[hi];
				frame_re[i] = r2ifft_pkg::DataW'(longint'(prev_re[lo])
					+ round_q16(br * wr - bi * wi));
				frame_im[i] = r2ifft_pkg::DataW'(longint'(prev_im[lo])
					+ round_q16(br * wi + bi * wr));
			end
		end
		for (int k = 0; k < Points; k++) begin
			r.result_re   = frame_re[bit_reverse(k)];
			r.result_im   = frame_im[bit_reverse(k)];
			r.result_last = (k == Points - 1);
			expected_points.push_back(r);
		end
	endtask

	assign pending_points = expected_points.size();

	always @(posedge clk or negedge arst_n) begin
		r2ifft_pkg::result_t e;
		if (!arst_n) begin
			samples_loaded = 0;
			fail_count     = 0;
		end else begin
			if (in_valid && !in_stall) begin
				frame_re[samples_loaded] = r2ifft_pkg::DataW'(in_data.sample_re);
				frame_im[samples_loaded] = r2ifft_pkg::DataW'(in_data.sample_im);
				samples_loaded++;
				if (samples_loaded == Points) begin
					samples_loaded = 0;
					predict_frame();
				end
			end
			if (out_valid && !out_stall) begin
				if (expected_points.size() == 0) begin
					$error("unexpected output point %p", out_data);
					fail_count++;
				end else begin
					e = expected_points.pop_front();
					if (out_data.result_re !== e.result_re) begin
						$error("result_re expected %0d got %0d", e.result_re, out_data.result_re);
						fail_count++;
					end
					if (out_data.result_im !== e.result_im) begin
						$error("result_im expected %0d got %0d", e.result_im, out_data.result_im);
						fail_count++;
					end
					if (out_data.result_last !== e.result_last) begin
						$error("result_last expected %0b got %0b", e.result_last,
							out_data.result_last);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

/* test/tb_radix2_inverse_fft_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radix2_inverse_fft_core: testbench top for the inverse FFT core
// Streams directed and random frames under several idle/stall mixes, including
// a long receiver hold-off; the checker predicts and compares each point.
// ----------------------------------------------------------------------------
module tb_radix2_inverse_fft_core;

	localparam int Log2Points  = 6;
	localparam int Points      = 1 << Log2Points;
	localparam int Frames      = 7;           // 448 samples, directed ones included
	localparam int CycleLimit  = 1_000_000;
	localparam int HoldOff     = 6000;        // longer than one compute phase

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	r2ifft_pkg::sample_t in_data;
	logic                out_valid;
	logic                out_stall;
	r2ifft_pkg::result_t out_data;
	int                  fail_count;
	int                  pending_points;

	// idle odds in percent; the receiver also honors a long hold-off request
	int      send_idle_pct;
	int      recv_stall_pct;
	logic    hold_off_start;
	logic    hold_off_done;
	int      hold_off_cycles;
	longint  cycle_count = 0;

	radix2_inverse_fft_core #(.LOG2_POINTS(Log2Points)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	tb_radix2_inverse_fft_checker #(.LOG2_POINTS(Log2Points)) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_data       (out_data),
		.fail_count     (fail_count),
		.pending_points (pending_points)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Hold-off counter: load once on request, then count down.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_off_cycles <= 0;
			hold_off_done   <= 1'b0;
		end else if (hold_off_start && !hold_off_done) begin
			hold_off_cycles <= HoldOff;
			hold_off_done   <= 1'b1;
		end else if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
		end
	end

	// Receiver: stall through a pending hold-off, else stall at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_off_cycles > 0) begin
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Draw one sample: mostly random, sometimes an extreme, sometimes real-only.
	function automatic r2ifft_pkg::sample_t random_sample();
		r2ifft_pkg::sample_t s;
		s.sample_re = 16'($urandom);
		s.sample_im = 16'($urandom);
		case ($urandom_range(9))
			0: s.sample_re = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			1: s.sample_im = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			2: s.sample_im = '0;
			default: ;
		endcase
		return s;
	endfunction

	// Offer one transaction; gap at random first, then hold until accepted.
	task automatic send_sample(input r2ifft_pkg::sample_t s);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_frame(input int kind);
		r2ifft_pkg::sample_t s;
		for (int i = 0; i < Points; i++) begin
			case (kind)
				0: s = r2ifft_pkg::sample_t'{16'sh7fff, 16'sh7fff};   // full-scale positive
				1: s = r2ifft_pkg::sample_t'{16'sh8000, 16'sh8000};   // full-scale negative
				2: s = (i == 0) ? r2ifft_pkg::sample_t'{16'sh7fff, 16'sh0000}
					: r2ifft_pkg::sample_t'{16'sh0000, 16'sh0000}; // impulse
				3: s = (i[0]) ? r2ifft_pkg::sample_t'{16'sh8000, 16'sh7fff}
					: r2ifft_pkg::sample_t'{16'sh7fff, 16'sh8000};  // alternating
				default: s = random_sample();
			endcase
			send_sample(s);
		end
	endtask

	initial begin
		in_valid        = 1'b0;
		in_data         = '0;
		arst_n          = 1'b0;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		hold_off_start  = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames: extremes, impulse, alternating signs; no idling.
		for (int k = 0; k < 4; k++) send_frame(k);

		// Random frames across the idle phases.
		for (int f = 0; f < Frames - 4; f++) begin
			case (f)
				0: begin send_idle_pct = 66; recv_stall_pct = 0;  end
				1: begin send_idle_pct = 0;  recv_stall_pct = 66; end
				default: begin send_idle_pct = 28; recv_stall_pct = 28; end
			endcase
			// Long receiver hold-off while the next frame is being offered.
			if (f == 1) hold_off_start <= 1'b1;
			send_frame(4);
		end
		in_valid <= 1'b0;

		repeat (2) @(posedge clk);
		while (pending_points != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
